// ===== src/sitc_pkg.sv =====
// ----------------------------------------------------------------------------
// sitc_pkg: shared definitions for the spiral index to coordinate unit.
// Holds the coordinate width, the index limit and the per-stage control type.
// ----------------------------------------------------------------------------
package sitc_pkg;

   localparam int COORD_WIDTH = 30;

   // Indices above this limit are flagged and give the origin.
   localparam logic [63:0] SPIRAL_MAX_INDEX = 64'd1000000000000000000;

   typedef struct packed {
      logic valid;
      logic too_large;
   } sitc_ctl_type;

endpackage

// ===== src/spiral_index_to_coordinate_unit.sv =====
// ----------------------------------------------------------------------------
// spiral_index_to_coordinate_unit: spiral index to signed (x, y) lattice point.
// One root bit per square-root stage, then the side, square, offset and output stages.
// Throughput is one item per cycle; the whole pipeline holds while a result is stalled.
// Synchronous active-high reset empties the pipeline; there is no clearing pass.
// ----------------------------------------------------------------------------
module spiral_index_to_coordinate_unit
   import sitc_pkg::*;
#(
   parameter int INDEX_WIDTH = 60
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [INDEX_WIDTH-1:0]         req_spiral_index,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [COORD_WIDTH-1:0]  rsp_coord_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_coord_y,
   output logic                           rsp_index_too_large
);

   localparam int ROOT_WIDTH = (INDEX_WIDTH + 1) / 2;
   localparam int SIDE_WIDTH = ROOT_WIDTH + 1;
   localparam int SQ_WIDTH   = 2 * SIDE_WIDTH;
   localparam int NUM_WIDTH  = ROOT_WIDTH + 3;
   localparam int DIF_WIDTH  = (NUM_WIDTH > COORD_WIDTH) ? NUM_WIDTH : COORD_WIDTH;

   logic advance;
   sitc_ctl_type in_ctl;
   sitc_ctl_type sq_ctl;
   logic [INDEX_WIDTH-1:0] sq_index;
   logic [ROOT_WIDTH-1:0]  sq_root;

   // Every stage moves together; the output register is the last stage.
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      in_ctl.valid     = req_valid;
      in_ctl.too_large = (64'(req_spiral_index) > SPIRAL_MAX_INDEX);
   end

   sitc_isqrt #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_ctl    (in_ctl),
      .in_index  (req_spiral_index),
      .out_ctl   (sq_ctl),
      .out_index (sq_index),
      .out_root  (sq_root)
   );

   // Side stage: odd ring side s from the root.
   sitc_ctl_type            side_ctl_ff;
   logic [INDEX_WIDTH-1:0]  side_index_ff;
   logic [SIDE_WIDTH-1:0]   side_ff;
   logic [SIDE_WIDTH-1:0]   side_in;

   assign side_in = SIDE_WIDTH'(sq_root) + (sq_root[0] ? SIDE_WIDTH'(2) : SIDE_WIDTH'(1));

   // Square stage: corner value q = s * s.
   sitc_ctl_type            sqr_ctl_ff;
   logic [INDEX_WIDTH-1:0]  sqr_index_ff;
   logic [SIDE_WIDTH-1:0]   sqr_side_ff;
   logic [SQ_WIDTH-1:0]     corner_ff;
   logic [SQ_WIDTH-1:0]     corner_in;

   assign corner_in = SQ_WIDTH'(side_ff) * SQ_WIDTH'(side_ff);

   // Offset stage: u = q - 1 - t counts back from the corner, with the side
   // boundaries m, 2m, 3m (m = s - 1) and the multiples of h = m / 2.
   sitc_ctl_type           off_ctl_ff;
   logic [NUM_WIDTH-1:0]   back_ff,  back_in;
   logic [NUM_WIDTH-1:0]   m1_ff,    m1_in;
   logic [NUM_WIDTH-1:0]   m2_ff,    m2_in;
   logic [NUM_WIDTH-1:0]   m3_ff,    m3_in;
   logic [NUM_WIDTH-1:0]   h1_ff,    h1_in;
   logic [NUM_WIDTH-1:0]   h3_ff,    h3_in;
   logic [NUM_WIDTH-1:0]   h5_ff,    h5_in;
   logic [NUM_WIDTH-1:0]   h7_ff,    h7_in;
   logic [SQ_WIDTH-1:0]    back_full;

   always_comb begin
      back_full = corner_ff - SQ_WIDTH'(1) - SQ_WIDTH'(sqr_index_ff);
      back_in   = back_full[NUM_WIDTH-1:0];
      m1_in     = NUM_WIDTH'(sqr_side_ff) - NUM_WIDTH'(1);
      m2_in     = {m1_in[NUM_WIDTH-2:0], 1'b0};
      m3_in     = m1_in + m2_in;
      h1_in     = NUM_WIDTH'(sqr_side_ff[SIDE_WIDTH-1:1]);
      h3_in     = h1_in + {h1_in[NUM_WIDTH-2:0], 1'b0};
      h5_in     = h1_in + {h1_in[NUM_WIDTH-3:0], 2'b00};
      h7_in     = {h1_in[NUM_WIDTH-4:0], 3'b000} - h1_in;
   end

   // Output stage: pick the side of the ring and the place along it.
   logic                   rsp_valid_ff;
   logic                   rsp_flag_ff;
   logic [COORD_WIDTH-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_WIDTH-1:0] rsp_y_ff, rsp_y_in;
   logic [DIF_WIDTH-1:0]   pos_h, neg_h, right_y, bottom_x, left_y, top_x;
   logic [DIF_WIDTH-1:0]   x_sel, y_sel;

   always_comb begin
      pos_h    = DIF_WIDTH'(h1_ff);
      neg_h    = DIF_WIDTH'(0) - DIF_WIDTH'(h1_ff);
      right_y  = DIF_WIDTH'(h1_ff) - DIF_WIDTH'(back_ff);
      bottom_x = DIF_WIDTH'(h3_ff) - DIF_WIDTH'(back_ff);
      left_y   = DIF_WIDTH'(back_ff) - DIF_WIDTH'(h5_ff);
      top_x    = DIF_WIDTH'(back_ff) - DIF_WIDTH'(h7_ff);
      if (back_ff <= m1_ff) begin
         x_sel = pos_h;
         y_sel = right_y;
      end else if (back_ff <= m2_ff) begin
         x_sel = bottom_x;
         y_sel = neg_h;
      end else if (back_ff <= m3_ff) begin
         x_sel = neg_h;
         y_sel = left_y;
      end else begin
         x_sel = top_x;
         y_sel = pos_h;
      end
      if (off_ctl_ff.too_large) begin
         rsp_x_in = '0;
         rsp_y_in = '0;
      end else begin
         rsp_x_in = x_sel[COORD_WIDTH-1:0];
         rsp_y_in = y_sel[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ctl_ff  <= '0;
         sqr_ctl_ff   <= '0;
         off_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         side_ctl_ff  <= sq_ctl;
         sqr_ctl_ff   <= side_ctl_ff;
         off_ctl_ff   <= sqr_ctl_ff;
         rsp_valid_ff <= off_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_index_ff <= sq_index;
         side_ff       <= side_in;
         sqr_index_ff  <= side_index_ff;
         sqr_side_ff   <= side_ff;
         corner_ff     <= corner_in;
         back_ff       <= back_in;
         m1_ff         <= m1_in;
         m2_ff         <= m2_in;
         m3_ff         <= m3_in;
         h1_ff         <= h1_in;
         h3_ff         <= h3_in;
         h5_ff         <= h5_in;
         h7_ff         <= h7_in;
         rsp_flag_ff   <= off_ctl_ff.too_large;
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coord_x         = $signed(rsp_x_ff);
   assign rsp_coord_y         = $signed(rsp_y_ff);
   assign rsp_index_too_large = rsp_flag_ff;

endmodule

// ===== src/sitc_isqrt.sv =====
// ----------------------------------------------------------------------------
// sitc_isqrt: pipelined exact integer square root.
// One root bit is resolved per register stage, most significant pair first.
// The index and the control bits travel with each item.
// ----------------------------------------------------------------------------
module sitc_isqrt
   import sitc_pkg::*;
#(
   parameter int INDEX_WIDTH = 60
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  sitc_ctl_type                        in_ctl,
   input  logic [INDEX_WIDTH-1:0]              in_index,
   output sitc_ctl_type                        out_ctl,
   output logic [INDEX_WIDTH-1:0]              out_index,
   output logic [(INDEX_WIDTH + 1) / 2 - 1:0]  out_root
);

   localparam int ROOT_WIDTH = (INDEX_WIDTH + 1) / 2;
   localparam int PAD_WIDTH  = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH  = ROOT_WIDTH + 2;

   sitc_ctl_type            ctl_ff   [ROOT_WIDTH];
   logic [INDEX_WIDTH-1:0]  index_ff [ROOT_WIDTH];
   logic [REM_WIDTH-1:0]    rem_ff   [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0]   root_ff  [ROOT_WIDTH];

   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_digit
      sitc_ctl_type            ctl_prev;
      logic [INDEX_WIDTH-1:0]  index_prev;
      logic [REM_WIDTH-1:0]    rem_prev;
      logic [ROOT_WIDTH-1:0]   root_prev;
      logic [PAD_WIDTH-1:0]    pad_index;
      logic [1:0]              pair;
      logic [REM_WIDTH-1:0]    rem_shift;
      logic [REM_WIDTH-1:0]    trial;
      logic [REM_WIDTH-1:0]    rem_diff;
      logic                    fits;
      logic [REM_WIDTH-1:0]    rem_in;
      logic [ROOT_WIDTH-1:0]   root_in;

      if (i == 0) begin : g_first
         assign ctl_prev   = in_ctl;
         assign index_prev = in_index;
         assign rem_prev   = '0;
         assign root_prev  = '0;
      end else begin : g_next
         assign ctl_prev   = ctl_ff[i-1];
         assign index_prev = index_ff[i-1];
         assign rem_prev   = rem_ff[i-1];
         assign root_prev  = root_ff[i-1];
      end

      // The remainder stays at most twice the partial root, so its top two bits
      // are zero before the shift and the trial value fits the same width.
      always_comb begin
         pad_index = PAD_WIDTH'(index_prev);
         pair      = pad_index[PAD_WIDTH-1-2*i -: 2];
         rem_shift = {rem_prev[REM_WIDTH-3:0], pair};
         trial     = {root_prev, 2'b01};
         rem_diff  = rem_shift - trial;
         fits      = (rem_shift >= trial);
         rem_in    = fits ? rem_diff : rem_shift;
         root_in   = {root_prev[ROOT_WIDTH-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (advance) begin
            ctl_ff[i] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            index_ff[i] <= index_prev;
            rem_ff[i]   <= rem_in;
            root_ff[i]  <= root_in;
         end
      end
   end

   assign out_ctl   = ctl_ff[ROOT_WIDTH-1];
   assign out_index = index_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];

endmodule
